// File: src/leek_pkg.sv
`timescale 1ns / 1ps

package leek_pkg;

   localparam int LINE_DEPTH = 63;
   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam int CNT_W = $clog2(LINE_DEPTH + 1);

   localparam logic [7:0] CH_ERASE   = 8'd35;
   localparam logic [7:0] CH_KILL    = 8'd64;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// File: src/line_editor_erase_kill_top.sv
`timescale 1ns / 1ps

// channel   ports                        fields (low bit up)
// req       req_tvalid/tready/tdata/user tdata: char_in[7:0]; tuser: end_of_input
// rsp       rsp_tvalid/tready/tdata/last tdata: char_out[7:0]; tlast: last;
//           rsp_tuser                    tuser: truncated
//
// an ordinary, erase or kill character, or an end of input on an idle line, is taken at once
// a newline, or an end of input on a started line, holds off req until the line drains:
// one line-store read per cycle while rsp does not stall, each read passing through the
// read register, then the closing newline; an empty line sends only the closing newline
// no clearing pass for the line store; reset clears fill count, started and overflow flags
// a stalled rsp holds the drain; the output register lets req resume while the
// closing newline still waits

module line_editor_erase_kill_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_in[7:0]
   input  logic       req_tuser,   // end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // char_out[7:0]
   output logic       rsp_tlast,
   output logic       rsp_tuser    // truncated
);

   logic [7:0] mem [leek_pkg::LINE_DEPTH];

   leek_pkg::state_type state_ff, state_in;
   logic [leek_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [leek_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic started_ff, started_in;
   logic ovf_ff, ovf_in;
   logic trunc_ff, trunc_in;
   logic rd_pend_ff, rd_pend_in;
   logic [7:0] mem_q_ff;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in;
   logic out_trunc_ff, out_trunc_in;

   logic accept, out_free, issue, move, finish, flush, do_write, drain;

   assign req_tready = (state_ff == leek_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign drain      = (state_ff == leek_pkg::ST_DRAIN);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign issue      = drain && (rd_idx_ff != fill_ff) && (!rd_pend_ff || out_free);
   assign move       = rd_pend_ff && out_free;
   assign finish     = drain && (rd_idx_ff == fill_ff) && !rd_pend_ff && out_free;
   assign flush      = accept && (req_tuser ? started_ff
                                            : (req_tdata == leek_pkg::CH_NEWLINE));
   assign do_write   = accept && !req_tuser
                       && (req_tdata != leek_pkg::CH_NEWLINE)
                       && (req_tdata != leek_pkg::CH_ERASE)
                       && (req_tdata != leek_pkg::CH_KILL)
                       && (fill_ff < leek_pkg::CNT_W'(leek_pkg::LINE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      started_in   = started_ff;
      ovf_in       = ovf_ff;
      trunc_in     = trunc_ff;
      rd_pend_in   = rd_pend_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;

      if (flush) begin
         state_in  = leek_pkg::ST_DRAIN;
         rd_idx_in = '0;
         trunc_in  = ovf_ff;
      end else if (accept && !req_tuser) begin
         started_in = 1'b1;
         priority if (req_tdata == leek_pkg::CH_ERASE) begin
            if (fill_ff != '0) fill_in = fill_ff - leek_pkg::CNT_W'(1);
         end else if (req_tdata == leek_pkg::CH_KILL) begin
            fill_in = '0;
         end else if (do_write) begin
            fill_in = fill_ff + leek_pkg::CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (issue) rd_idx_in = rd_idx_ff + leek_pkg::CNT_W'(1);

      if (issue)     rd_pend_in = 1'b1;
      else if (move) rd_pend_in = 1'b0;

      priority if (move) begin
         out_valid_in = 1'b1;
         out_data_in  = mem_q_ff;
         out_last_in  = 1'b0;
         out_trunc_in = trunc_ff;
      end else if (finish) begin
         out_valid_in = 1'b1;
         out_data_in  = leek_pkg::CH_NEWLINE;
         out_last_in  = 1'b1;
         out_trunc_in = trunc_ff;
         state_in     = leek_pkg::ST_IDLE;
         fill_in      = '0;
         started_in   = 1'b0;
         ovf_in       = 1'b0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[fill_ff[leek_pkg::IDX_W-1:0]] <= req_tdata;
      if (issue) mem_q_ff <= mem[rd_idx_ff[leek_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= leek_pkg::ST_IDLE;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trunc_ff     <= trunc_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

endmodule

// File: src/leek_checker.sv
`timescale 1ns / 1ps

module leek_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == leek_pkg::CH_NEWLINE)
      else $error("closing item is not a newline");

   // a newline item starts a drain, input waits
   a_newline_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && req_tdata == leek_pkg::CH_NEWLINE
         |=> !req_tready)
      else $error("input taken right after newline");

   // line characters only go out while input is held off
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during drain");

endmodule

bind line_editor_erase_kill_top leek_checker u_leek_checker (.*);
